@@ sv/assert_macros.svh @@
// Assertion macros shared by the page mapper RTL.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define EPM_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define EPM_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define EPM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/epm_pkg.sv @@
// Package of the expanded-memory page mapper: mode codes, port and command constants,
// and the page base computation. It depends on nothing else.
`default_nettype none

package epm_pkg;

	typedef enum logic [1:0] {
		MODE_IO_WR = 2'd0,
		MODE_IO_RD = 2'd1,
		MODE_MEM   = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	localparam int unsigned APB_AW = 3;

	localparam logic REG_MEM_SIZE  = 1'b0;
	localparam logic REG_FN_NOTIFY = 1'b1;

	localparam logic [14:0] MEM_SIZE_RESET = 15'd1024;

	localparam logic [13:0] PORT_BANK0 = 14'h0208;
	localparam logic [13:0] PORT_BANK1 = 14'h0218;
	localparam logic [13:0] PORT_BANK2 = 14'h0258;
	localparam logic [13:0] PORT_BANK3 = 14'h0268;
	localparam logic [15:0] PORT_SYS   = 16'h8084;

	localparam logic [2:0] CMD_LAYOUT  = 3'b010;
	localparam logic [3:0] SYS_RD_LOW  = 4'hC;
	localparam logic [7:0] FRAME_SEG   = 8'h0D;
	localparam logic [7:0] RD_IDLE     = 8'hFF;

	localparam logic [19:0] UPPER_START_640 = 20'hA0000;
	localparam logic [19:0] UPPER_START_512 = 20'h80000;
	localparam logic [5:0]  UPPER_PAGES_640 = 6'd24;
	localparam logic [5:0]  UPPER_PAGES_512 = 6'd32;
	localparam logic [24:0] UPPER_LEN_640   = 25'h060000;
	localparam logic [24:0] UPPER_LEN_512   = 25'h080000;
	localparam logic [24:0] ONE_MEG         = 25'h100000;

	// RAM base of a 16 KB page, or zero when the page is disabled or lies past RAM.
	function automatic logic [23:0] page_base(input logic [1:0] bank, input logic [7:0] val,
			input logic uems, input logic c640, input logic [14:0] msize);
		logic [8:0]  pg;
		logic [5:0]  ucnt;
		logic [19:0] ustart;
		logic [24:0] top;
		logic [24:0] lim;
		logic [9:0]  pg1;
		logic [24:0] res;
		logic [23:0] r;
		pg     = {2'b00, val[6:0]} + {bank, 7'b0};
		ucnt   = c640 ? UPPER_PAGES_640 : UPPER_PAGES_512;
		ustart = c640 ? UPPER_START_640 : UPPER_START_512;
		top    = {msize, 10'b0};
		r      = '0;
		if (val[7]) begin
			if (uems && (pg < {3'b000, ucnt})) begin
				r = {4'h0, ustart} + {5'b0, pg[4:0], 14'b0};
			end else begin
				if (uems) begin
					pg = pg - {3'b000, ucnt};
				end
				lim = {2'b00, pg, 14'b0} + ONE_MEG;
				pg1 = {1'b0, pg} + 10'd1;
				res = top - {1'b0, pg1, 14'b0};
				if (lim < top) begin
					r = res[23:0];
				end
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ sv/epm_ram.sv @@
// Generic single-write, single-read synchronous RAM with a registered read port.
// Used for the page registers and the frame slot bases; no dependencies.
`default_nettype none

module epm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ sv/ems_page_mapper_core.sv @@
// Top level of the expanded-memory page mapper: I/O decode, page memories and translation.
// Depends on epm_pkg, epm_ram and assert_macros.svh.
//
// The mapper takes one transaction per cycle on its input channel. The result transaction for
// each is registered in stage 1, stage 2 and the output register; a stalled output holds the
// pipeline and the input. Page registers and frame slot bases live in two small synchronous
// RAMs that are read and written in the first pipeline stage. A layout command on the system
// port recomputes the four frame slots through the page RAM read port, one slot per cycle,
// and holds the input off meanwhile. Configuration writes take effect on later transactions
// only if the user makes them with the pipeline empty; the block itself does not enforce it.
`default_nettype none

module ems_page_mapper_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [epm_pkg::APB_AW-1:0]  paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output logic                             pready,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [1:0]                  mode,
	input  wire logic [15:0]                 io_port,
	input  wire logic [7:0]                  write_data,
	input  wire logic [23:0]                 mem_addr,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic      [7:0]                  read_data,
	output logic                             port_hit,
	output logic                             mem_hit,
	output logic      [23:0]                 phys_addr,
	output logic                             high_ram_on,
	output logic                             conv_640k
);

	// Configuration and layout state.
	logic [14:0] mem_size_q;
	logic [3:0]  fn_notify_q;
	logic        c640_q;
	logic        uems_q;
	logic        hen_q;
	logic        uxms_q;
	logic [15:0] page_vld_q;
	logic [3:0]  slot_vld_q;
	logic        pg_rvld_q;
	logic        sweep_busy_q;
	logic [2:0]  sweep_cnt_q;

	// Stage 1: registered input transaction.
	logic        valid_s1;
	logic [1:0]  mode_s1;
	logic [15:0] port_s1;
	logic [7:0]  wdata_s1;
	logic [23:0] addr_s1;

	// Stage 2: decoded transaction waiting for RAM data.
	logic        valid_s2;
	logic        phit_s2;
	logic        pgrd_s2;
	logic [7:0]  rdfix_s2;
	logic        frame_s2;
	logic        slot_vld_s2;
	logic [13:0] off_s2;
	logic        xms_s2;
	logic [23:0] xphys_s2;
	logic        hen_s2;
	logic        c640_s2;

	// Output register.
	logic        out_valid_q;
	logic [7:0]  read_data_q;
	logic        port_hit_q;
	logic        mem_hit_q;
	logic [23:0] phys_addr_q;
	logic        high_ram_on_q;
	logic        conv_640k_q;

	logic        cfg_wr;
	logic        out_take;
	logic        s1_adv;
	logic [1:0]  bank;
	logic        bank_hit;
	logic [3:0]  idx;
	logic        is_io;
	logic        sys_hit;
	logic        pg_wr;
	logic        pg_rd;
	logic        layout;
	logic        frame;
	logic        c640_nx;
	logic        uems_nx;
	logic        hen_nx;
	logic        uxms_nx;
	logic [7:0]  rdfix;
	logic [24:0] top;
	logic [24:0] addr_x;
	logic [24:0] diff;
	logic [24:0] ulen;
	logic [19:0] ustart;
	logic        xms;
	logic [23:0] xphys;
	logic        sweep_rd;
	logic        sweep_wr;
	logic [2:0]  sweep_wcnt;
	logic [7:0]  sweep_val;
	logic        pram_re;
	logic [3:0]  pram_raddr;
	logic [7:0]  pram_rdata;
	logic        sram_we;
	logic [1:0]  sram_waddr;
	logic [23:0] sram_wdata;
	logic        sram_re;
	logic [23:0] sram_rdata;
	logic        slot_hit;
	logic        mem_hit_nx;
	logic [23:0] phys_nx;
	logic [7:0]  rd_nx;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;
	assign prdata = (paddr[2] == epm_pkg::REG_FN_NOTIFY) ? {28'b0, fn_notify_q}
		: {17'b0, mem_size_q};

	// Handshake chain from the output back to the input.
	assign out_take = valid_s2 & (~out_valid_q | out_ready);
	assign s1_adv   = valid_s1 & (~valid_s2 | out_take);
	assign in_ready = ~sweep_busy_q & ~(valid_s1 & layout) & (~valid_s1 | s1_adv);

	// Port decode of the stage 1 transaction.
	always_comb begin
		bank_hit = 1'b1;
		bank     = 2'd0;
		case (port_s1[13:0])
			epm_pkg::PORT_BANK0: bank = 2'd0;
			epm_pkg::PORT_BANK1: bank = 2'd1;
			epm_pkg::PORT_BANK2: bank = 2'd2;
			epm_pkg::PORT_BANK3: bank = 2'd3;
			default: bank_hit = 1'b0;
		endcase
	end

	assign idx     = {bank, port_s1[15:14]};
	assign is_io   = (mode_s1 == epm_pkg::MODE_IO_WR) || (mode_s1 == epm_pkg::MODE_IO_RD);
	assign sys_hit = is_io & ~bank_hit & (port_s1 == epm_pkg::PORT_SYS);
	assign pg_wr   = (mode_s1 == epm_pkg::MODE_IO_WR) & bank_hit;
	assign pg_rd   = (mode_s1 == epm_pkg::MODE_IO_RD) & bank_hit;
	assign layout  = (mode_s1 == epm_pkg::MODE_IO_WR) & sys_hit
		& (wdata_s1[7:5] == epm_pkg::CMD_LAYOUT);
	assign frame   = (mode_s1 == epm_pkg::MODE_MEM) & (addr_s1[23:16] == epm_pkg::FRAME_SEG);
	assign rdfix   = (sys_hit && (mode_s1 == epm_pkg::MODE_IO_RD))
		? {fn_notify_q, epm_pkg::SYS_RD_LOW} : epm_pkg::RD_IDLE;

	assign c640_nx = layout ? wdata_s1[2] : c640_q;
	assign uems_nx = layout ? wdata_s1[0] : uems_q;
	assign hen_nx  = layout ? wdata_s1[1] : hen_q;
	assign uxms_nx = layout ? (wdata_s1[4] & wdata_s1[1]) : uxms_q;

	// Upper XMS window above the top of installed RAM.
	assign top    = {mem_size_q, 10'b0};
	assign addr_x = {1'b0, addr_s1};
	assign diff   = addr_x - top;
	assign ulen   = c640_q ? epm_pkg::UPPER_LEN_640 : epm_pkg::UPPER_LEN_512;
	assign ustart = c640_q ? epm_pkg::UPPER_START_640 : epm_pkg::UPPER_START_512;
	assign xms    = (mode_s1 == epm_pkg::MODE_MEM) & uxms_q & (addr_x >= top) & (diff < ulen);
	assign xphys  = diff[23:0] + {4'h0, ustart};

	// Slot recompute sequencer after a layout command.
	assign sweep_rd   = sweep_busy_q & ~sweep_cnt_q[2];
	assign sweep_wr   = sweep_busy_q & (sweep_cnt_q != 3'd0);
	assign sweep_wcnt = sweep_cnt_q - 3'd1;
	assign sweep_val  = pg_rvld_q ? pram_rdata : 8'h00;

	assign pram_re    = (s1_adv & pg_rd) | sweep_rd;
	assign pram_raddr = sweep_busy_q ? {2'b00, sweep_cnt_q[1:0]} : idx;

	assign sram_we    = (s1_adv & pg_wr) | sweep_wr;
	assign sram_waddr = sweep_busy_q ? sweep_wcnt[1:0] : port_s1[15:14];
	assign sram_wdata = sweep_busy_q
		? epm_pkg::page_base(2'd0, sweep_val, uems_q, c640_q, mem_size_q)
		: epm_pkg::page_base(bank, wdata_s1, uems_q, c640_q, mem_size_q);
	assign sram_re    = s1_adv & frame;

	epm_ram #(
		.WIDTH(8),
		.DEPTH(16)
	) u_page_ram (
		.clk  (clk),
		.we   (s1_adv & pg_wr),
		.waddr(idx),
		.wdata(wdata_s1),
		.re   (pram_re),
		.raddr(pram_raddr),
		.rdata(pram_rdata)
	);

	epm_ram #(
		.WIDTH(24),
		.DEPTH(4)
	) u_slot_ram (
		.clk  (clk),
		.we   (sram_we),
		.waddr(sram_waddr),
		.wdata(sram_wdata),
		.re   (sram_re),
		.raddr(addr_s1[15:14]),
		.rdata(sram_rdata)
	);

	// Result assembly from stage 2 and the RAM read data.
	assign slot_hit   = frame_s2 & slot_vld_s2 & (sram_rdata != 24'd0);
	assign mem_hit_nx = slot_hit | xms_s2;
	assign phys_nx    = slot_hit ? (sram_rdata + {10'b0, off_s2})
		: (xms_s2 ? xphys_s2 : 24'd0);
	assign rd_nx      = pgrd_s2 ? (pg_rvld_q ? pram_rdata : 8'h00) : rdfix_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_size_q   <= epm_pkg::MEM_SIZE_RESET;
			fn_notify_q  <= '0;
			c640_q       <= 1'b0;
			uems_q       <= 1'b0;
			hen_q        <= 1'b0;
			uxms_q       <= 1'b0;
			page_vld_q   <= '0;
			slot_vld_q   <= '0;
			pg_rvld_q    <= 1'b0;
			sweep_busy_q <= 1'b0;
			sweep_cnt_q  <= '0;
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr) begin
				if (paddr[2] == epm_pkg::REG_MEM_SIZE) begin
					mem_size_q <= pwdata[14:0];
				end else begin
					fn_notify_q <= pwdata[3:0];
				end
			end
			if (s1_adv) begin
				c640_q <= c640_nx;
				uems_q <= uems_nx;
				hen_q  <= hen_nx;
				uxms_q <= uxms_nx;
			end
			if (s1_adv && pg_wr) begin
				page_vld_q[idx] <= 1'b1;
			end
			if (sram_we) begin
				slot_vld_q[sram_waddr] <= 1'b1;
			end
			if (pram_re) begin
				pg_rvld_q <= page_vld_q[pram_raddr];
			end
			if (s1_adv && layout) begin
				sweep_busy_q <= 1'b1;
				sweep_cnt_q  <= '0;
			end else if (sweep_busy_q) begin
				if (sweep_cnt_q[2]) begin
					sweep_busy_q <= 1'b0;
				end
				sweep_cnt_q <= sweep_cnt_q + 3'd1;
			end
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				valid_s2 <= 1'b1;
			end else if (out_take) begin
				valid_s2 <= 1'b0;
			end
			if (out_take) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1  <= mode;
			port_s1  <= io_port;
			wdata_s1 <= write_data;
			addr_s1  <= mem_addr;
		end
		if (s1_adv) begin
			phit_s2     <= bank_hit & is_io | sys_hit;
			pgrd_s2     <= pg_rd;
			rdfix_s2    <= rdfix;
			frame_s2    <= frame;
			slot_vld_s2 <= slot_vld_q[addr_s1[15:14]];
			off_s2      <= addr_s1[13:0];
			xms_s2      <= xms;
			xphys_s2    <= xphys;
			hen_s2      <= hen_nx;
			c640_s2     <= c640_nx;
		end
		if (out_take) begin
			read_data_q   <= rd_nx;
			port_hit_q    <= phit_s2;
			mem_hit_q     <= mem_hit_nx;
			phys_addr_q   <= phys_nx;
			high_ram_on_q <= hen_s2;
			conv_640k_q   <= c640_s2;
		end
	end

	assign out_valid   = out_valid_q;
	assign read_data   = read_data_q;
	assign port_hit    = port_hit_q;
	assign mem_hit     = mem_hit_q;
	assign phys_addr   = phys_addr_q;
	assign high_ram_on = high_ram_on_q;
	assign conv_640k   = conv_640k_q;

`include "assert_macros.svh"

	`EPM_ASSERT_ALWAYS(a_sweep_excl_s1, !(sweep_busy_q && valid_s1), "slot recompute overlaps a stage 1 transaction")
	`EPM_ASSERT_IMPLY(a_sweep_blocks_in, sweep_busy_q, !in_ready, "input accepted during slot recompute")
	`EPM_ASSERT_NEXT(a_layout_starts_sweep, s1_adv && layout, sweep_busy_q && (sweep_cnt_q == 3'd0), "layout command did not start slot recompute")
	`EPM_ASSERT_IMPLY(a_hit_excl, out_valid_q, !(port_hit_q && mem_hit_q), "port and memory hit reported together")
	`EPM_ASSERT_IMPLY(a_miss_zero, out_valid_q && !mem_hit_q, phys_addr_q == 24'd0, "address reported on a memory miss")

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking testbench for ems_page_mapper_core: random and directed I/O and memory
// transactions, checked against a behavioral page-mapper predictor. Depends on epm_pkg.
// A queue-fed driver and a monitor run as clocked always blocks; APB sets the registers.
`timescale 1ns / 1ps
`default_nettype none

module testbench;

	typedef struct {
		epm_pkg::mode_t mode;
		logic [15:0]    io_port;
		logic [7:0]     write_data;
		logic [23:0]    mem_addr;
	} map_item_t;

	typedef struct {
		logic [7:0]  read_data;
		logic        port_hit;
		logic        mem_hit;
		logic [23:0] phys_addr;
		logic        high_ram_on;
		logic        conv_640k;
	} map_result_t;

	localparam int unsigned WATCHDOG_LIMIT = 3000;
	localparam int unsigned PHASES = 8;
	localparam int unsigned PHASE_ITEMS = 50;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  mode;
	logic [15:0] io_port;
	logic [7:0]  write_data;
	logic [23:0] mem_addr;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  read_data;
	logic        port_hit;
	logic        mem_hit;
	logic [23:0] phys_addr;
	logic        high_ram_on;
	logic        conv_640k;

	ems_page_mapper_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.io_port(io_port),
		.write_data(write_data),
		.mem_addr(mem_addr),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_data(read_data),
		.port_hit(port_hit),
		.mem_hit(mem_hit),
		.phys_addr(phys_addr),
		.high_ram_on(high_ram_on),
		.conv_640k(conv_640k)
	);

	// Predictor copy of the mapper state and its registers.
	logic [7:0]  pr_pages [16];
	logic [23:0] pr_slot [4];
	logic        pr_c640;
	logic        pr_uems;
	logic        pr_high;
	logic        pr_xms;
	logic [14:0] cfg_msize;
	logic [3:0]  cfg_notify;

	map_item_t   pending_items [$];
	map_result_t expected_maps [$];

	int unsigned in_taken;
	int unsigned in_gap;
	int unsigned in_burst;
	int unsigned out_hold;
	int unsigned out_burst;
	int unsigned quiet_cycles;
	int unsigned errors;
	int unsigned n_items;
	int unsigned n_results;
	int unsigned n_mem_hits;
	int unsigned n_layouts;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [23:0] umem_start();
		return pr_c640 ? {4'h0, epm_pkg::UPPER_START_640} : {4'h0, epm_pkg::UPPER_START_512};
	endfunction

	function automatic int unsigned umem_count();
		return pr_c640 ? 24 : 32;
	endfunction

	function automatic logic [23:0] frame_base_of(int idx, logic [7:0] val);
		int unsigned pg;
		int unsigned top;
		if (!val[7]) begin
			return '0;
		end
		pg = int'(val[6:0]) + 128 * (idx / 4);
		if (pr_uems) begin
			if (pg < umem_count()) begin
				return umem_start() + 24'(32'h4000 * pg);
			end
			pg = pg - umem_count();
		end
		top = {7'b0, cfg_msize, 10'b0};
		if (pg * 32'h4000 + 32'h100000 >= top) begin
			return '0;
		end
		return 24'(top - 32'h4000 * (pg + 1));
	endfunction

	function automatic int reg_index(logic [15:0] port);
		int bank;
		case (port[13:0])
			epm_pkg::PORT_BANK0: bank = 0;
			epm_pkg::PORT_BANK1: bank = 1;
			epm_pkg::PORT_BANK2: bank = 2;
			epm_pkg::PORT_BANK3: bank = 3;
			default: bank = -1;
		endcase
		if (bank < 0) begin
			return -1;
		end
		return bank * 4 + int'(port[15:14]);
	endfunction

	function automatic void load_page(int idx, logic [7:0] val);
		pr_slot[idx % 4] = frame_base_of(idx, val);
		pr_pages[idx] = val;
	endfunction

	function automatic void apply_layout(logic [4:0] v);
		pr_c640 = v[2];
		pr_uems = v[0];
		pr_high = v[1];
		pr_xms = v[4] & v[1];
		for (int n = 0; n < 4; n++) begin
			load_page(n, pr_pages[n]);
		end
	endfunction

	function automatic map_result_t predict_map(map_item_t it);
		map_result_t r;
		int idx;
		int unsigned top;
		int unsigned a;
		logic [23:0] b;
		r.read_data = epm_pkg::RD_IDLE;
		r.port_hit = 1'b0;
		r.mem_hit = 1'b0;
		r.phys_addr = '0;
		case (it.mode)
			epm_pkg::MODE_IO_WR, epm_pkg::MODE_IO_RD: begin
				idx = reg_index(it.io_port);
				if (idx >= 0) begin
					r.port_hit = 1'b1;
					if (it.mode == epm_pkg::MODE_IO_WR) begin
						load_page(idx, it.write_data);
					end else begin
						r.read_data = pr_pages[idx];
					end
				end else if (it.io_port == epm_pkg::PORT_SYS) begin
					r.port_hit = 1'b1;
					if (it.mode == epm_pkg::MODE_IO_WR) begin
						if (it.write_data[7:5] == epm_pkg::CMD_LAYOUT) begin
							apply_layout(it.write_data[4:0]);
							n_layouts++;
						end
					end else begin
						r.read_data = {cfg_notify, epm_pkg::SYS_RD_LOW};
					end
				end
			end
			epm_pkg::MODE_MEM: begin
				top = {7'b0, cfg_msize, 10'b0};
				a = {8'b0, it.mem_addr};
				if (it.mem_addr[23:16] == epm_pkg::FRAME_SEG) begin
					b = pr_slot[it.mem_addr[15:14]];
					if (b != '0) begin
						r.mem_hit = 1'b1;
						r.phys_addr = b + {10'b0, it.mem_addr[13:0]};
					end
				end
				if (!r.mem_hit && pr_xms && a >= top && a - top < umem_count() * 32'h4000) begin
					r.mem_hit = 1'b1;
					r.phys_addr = 24'(a - top) + umem_start();
				end
			end
			default: begin
			end
		endcase
		r.high_ram_on = pr_high;
		r.conv_640k = pr_c640;
		return r;
	endfunction

	function automatic logic [15:0] page_port(int unsigned bank, logic [1:0] slot);
		logic [13:0] low;
		case (bank)
			0: low = epm_pkg::PORT_BANK0;
			1: low = epm_pkg::PORT_BANK1;
			2: low = epm_pkg::PORT_BANK2;
			default: low = epm_pkg::PORT_BANK3;
		endcase
		return {slot, low};
	endfunction

	function automatic map_item_t gen_item();
		map_item_t it;
		int unsigned sel;
		int unsigned top;
		it.mode = epm_pkg::mode_t'($urandom_range(0, 2));
		it.io_port = 16'($urandom);
		it.write_data = 8'($urandom);
		it.mem_addr = 24'($urandom);
		sel = $urandom_range(0, 99);
		if (sel < 25) begin
			it.mode = epm_pkg::MODE_IO_WR;
			it.io_port = page_port($urandom_range(0, 3), 2'($urandom));
			if ($urandom_range(0, 1) == 0) begin
				it.write_data[6:0] = 7'($urandom_range(0, 40));
			end
			it.write_data[7] = ($urandom_range(0, 4) != 0);
		end else if (sel < 35) begin
			it.mode = epm_pkg::MODE_IO_WR;
			it.io_port = epm_pkg::PORT_SYS;
			if ($urandom_range(0, 6) != 0) begin
				it.write_data[7:5] = epm_pkg::CMD_LAYOUT;
			end
		end else if (sel < 45) begin
			it.mode = epm_pkg::MODE_IO_RD;
			if ($urandom_range(0, 4) == 0) begin
				it.io_port = epm_pkg::PORT_SYS;
			end else begin
				it.io_port = page_port($urandom_range(0, 3), 2'($urandom));
			end
		end else if (sel < 80) begin
			it.mode = epm_pkg::MODE_MEM;
			sel = $urandom_range(0, 9);
			top = {7'b0, cfg_msize, 10'b0};
			if (sel < 5) begin
				it.mem_addr[23:16] = epm_pkg::FRAME_SEG;
			end else if (sel < 8) begin
				it.mem_addr = 24'(top + $urandom_range(0, 32'hA0000) - 32'h10000);
			end
		end else if (sel < 90) begin
			it.mode = epm_pkg::mode_t'($urandom_range(0, 3));
		end else begin
			it.mode = epm_pkg::mode_t'($urandom_range(0, 3));
			if ($urandom_range(0, 1) == 0) begin
				it.io_port = {2'($urandom), epm_pkg::PORT_SYS[13:0]};
			end
		end
		return it;
	endfunction

	function automatic int unsigned pick_idle();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 85) begin
			return $urandom_range(1, 3);
		end
		if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	task automatic add_item(epm_pkg::mode_t m, logic [15:0] port, logic [7:0] data,
			logic [23:0] addr);
		map_item_t it;
		it.mode = m;
		it.io_port = port;
		it.write_data = data;
		it.mem_addr = addr;
		pending_items.push_back(it);
	endtask

	task automatic apb_write(logic reg_sel, logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_sel, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_items.size() != 0 || in_valid || expected_maps.size() != 0) begin
			@(posedge clk);
		end
		repeat (12) @(posedge clk);
	endtask

	task automatic set_registers(logic [14:0] msize, logic [3:0] notify);
		apb_write(epm_pkg::REG_MEM_SIZE, {17'b0, msize});
		cfg_msize = msize;
		apb_write(epm_pkg::REG_FN_NOTIFY, {28'b0, notify});
		cfg_notify = notify;
	endtask

	// Driver: presents queued transactions at the falling edge, with random gaps.
	always @(negedge clk) begin
		if (!(in_valid && in_taken == 0)) begin
			in_taken = 0;
			if ($urandom_range(0, 49) == 0) begin
				in_burst = !in_burst;
			end
			if (in_gap > 0 && in_burst == 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (pending_items.size() != 0) begin
				map_item_t it;
				it = pending_items.pop_front();
				mode <= it.mode;
				io_port <= it.io_port;
				write_data <= it.write_data;
				mem_addr <= it.mem_addr;
				in_valid <= 1'b1;
				in_gap = pick_idle();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if ($urandom_range(0, 49) == 0) begin
			out_burst = !out_burst;
		end
		if (out_burst != 0) begin
			out_ready <= 1'b1;
		end else if (out_hold > 0) begin
			out_hold--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 3) == 0) begin
				out_hold = pick_idle();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			map_item_t it;
			it.mode = epm_pkg::mode_t'(mode);
			it.io_port = io_port;
			it.write_data = write_data;
			it.mem_addr = mem_addr;
			expected_maps.push_back(predict_map(it));
			in_taken = 1;
			n_items++;
		end
	end

	// Monitor: each result transaction is compared with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			map_result_t e;
			n_results++;
			if (expected_maps.size() == 0) begin
				errors++;
				if (errors <= 10) begin
					$display("Unexpected result transaction: rd=%h ph=%b mh=%b pa=%h",
						read_data, port_hit, mem_hit, phys_addr);
				end
			end else begin
				e = expected_maps.pop_front();
				if (e.mem_hit) begin
					n_mem_hits++;
				end
				if (read_data !== e.read_data || port_hit !== e.port_hit
						|| mem_hit !== e.mem_hit || phys_addr !== e.phys_addr
						|| high_ram_on !== e.high_ram_on || conv_640k !== e.conv_640k) begin
					errors++;
					if (errors <= 10) begin
						$display("Mismatch at result %0d: expected rd=%h ph=%b mh=%b pa=%h hi=%b c640=%b",
							n_results, e.read_data, e.port_hit, e.mem_hit, e.phys_addr,
							e.high_ram_on, e.conv_640k);
						$display("                      actual   rd=%h ph=%b mh=%b pa=%h hi=%b c640=%b",
							read_data, port_hit, mem_hit, phys_addr, high_ram_on, conv_640k);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("Watchdog expired with %0d results outstanding.", expected_maps.size());
					$display("CHECK FAILED");
					$finish;
				end
			end
		end
	end

	initial begin
		logic [14:0] phase_msize [PHASES];
		phase_msize = '{15'd2048, 15'd0, 15'd16384, 15'd32767, 15'd1100, 15'd4096,
			15'd1536, 15'd1024};
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		mode = '0;
		io_port = '0;
		write_data = '0;
		mem_addr = '0;
		out_ready = 1'b0;
		in_taken = 0;
		in_gap = 0;
		in_burst = 0;
		out_hold = 0;
		out_burst = 0;
		quiet_cycles = 0;
		errors = 0;
		n_items = 0;
		n_results = 0;
		n_mem_hits = 0;
		n_layouts = 0;
		for (int n = 0; n < 16; n++) begin
			pr_pages[n] = '0;
		end
		for (int n = 0; n < 4; n++) begin
			pr_slot[n] = '0;
		end
		pr_c640 = 1'b0;
		pr_uems = 1'b0;
		pr_high = 1'b0;
		pr_xms = 1'b0;
		cfg_msize = epm_pkg::MEM_SIZE_RESET;
		cfg_notify = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		add_item(epm_pkg::MODE_IO_RD, page_port(0, 2'd0), 8'h00, 24'h000000);
		add_item(epm_pkg::MODE_IO_RD, epm_pkg::PORT_SYS, 8'h00, 24'h000000);
		add_item(epm_pkg::MODE_IO_RD, 16'hFFFF, 8'hFF, 24'hFFFFFF);
		add_item(epm_pkg::MODE_MEM, 16'h0000, 8'h00, 24'h0D0000);
		add_item(epm_pkg::MODE_NONE, epm_pkg::PORT_SYS, 8'hFF, 24'hFFFFFF);
		add_item(epm_pkg::MODE_IO_WR, page_port(0, 2'd0), 8'h80, 24'h000000);
		add_item(epm_pkg::MODE_IO_WR, epm_pkg::PORT_SYS, 8'h5F, 24'h000000);
		add_item(epm_pkg::MODE_MEM, 16'h0000, 8'h00, 24'h0D0000);
		add_item(epm_pkg::MODE_IO_WR, page_port(0, 2'd3), 8'hFF, 24'h000000);
		add_item(epm_pkg::MODE_IO_WR, page_port(3, 2'd1), 8'h97, 24'h000000);
		add_item(epm_pkg::MODE_IO_WR, page_port(0, 2'd1), 8'h85, 24'h000000);
		add_item(epm_pkg::MODE_MEM, 16'h0000, 8'h00, 24'h0D7FFF);
		add_item(epm_pkg::MODE_MEM, 16'h0000, 8'h00, 24'h100000);
		add_item(epm_pkg::MODE_MEM, 16'h0000, 8'h00, 24'h15FFFF);
		add_item(epm_pkg::MODE_MEM, 16'h0000, 8'h00, 24'h160000);
		add_item(epm_pkg::MODE_IO_WR, epm_pkg::PORT_SYS, 8'hFF, 24'h000000);
		add_item(epm_pkg::MODE_IO_WR, epm_pkg::PORT_SYS, 8'h40, 24'h000000);
		add_item(epm_pkg::MODE_IO_RD, page_port(0, 2'd2), 8'h00, 24'h000000);
		add_item(epm_pkg::MODE_IO_WR, page_port(1, 2'd0), 8'h00, 24'h000000);
		add_item(epm_pkg::MODE_MEM, 16'h0000, 8'h00, 24'hFFFFFF);
		add_item(epm_pkg::MODE_MEM, 16'h0000, 8'h00, 24'h000000);
		add_item(epm_pkg::MODE_IO_WR, epm_pkg::PORT_SYS, 8'h52, 24'h000000);
		add_item(epm_pkg::MODE_MEM, 16'h0000, 8'h00, 24'h17FFFF);
		add_item(epm_pkg::MODE_IO_RD, page_port(3, 2'd3), 8'h00, 24'h000000);
		add_item(epm_pkg::MODE_IO_RD, 16'h0084, 8'h00, 24'h000000);

		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			if (p == 0) begin
				set_registers(phase_msize[p], 4'hF);
			end else if (p == 1) begin
				set_registers(phase_msize[p], 4'h0);
			end else begin
				set_registers(phase_msize[p], 4'($urandom));
			end
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				pending_items.push_back(gen_item());
			end
		end

		wait_drained();
		$display("Run covered %0d transactions over %0d register settings, %0d layout commands,",
			n_items, PHASES + 1, n_layouts);
		$display("and %0d results compared, %0d of them translated hits; %0d mismatches.",
			n_results, n_mem_hits, errors);
		if (errors == 0 && expected_maps.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+sv
sv/epm_pkg.sv
sv/epm_ram.sv
sv/ems_page_mapper_core.sv
tb/sv/testbench.sv
